// File: design/bpc_pkg.sv
// Shared types and constants for the block padding codec.
// Holds scheme and status codes, controller states and the command/status structs.
// No dependencies.
package bpc_pkg;

  localparam int MAX_BLOCK_DEF = 32;  // default window depth in bytes
  localparam int BSIZE_W       = 6;   // block length register width
  localparam int CFG_IDX_W     = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCHEME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BSIZE  = 2'd2;

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 6'd16;

  typedef enum logic [1:0] {
    SCH_ZERO  = 2'd0,
    SCH_X923  = 2'd1,
    SCH_PKCS7 = 2'd2,
    SCH_ISO   = 2'd3
  } scheme_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ALIGN  = 3'd1,
    ST_PADLEN = 3'd2,
    ST_PADBYT = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ITEM, S_BYTE, S_POP_WAIT, S_POP, S_PUSH, S_END, S_PAD,
    S_ZWAIT, S_ZCHK, S_LWAIT, S_LCHK, S_CWAIT, S_CCHK, S_RSTART,
    S_RWAIT, S_REL, S_MARK
  } state_t;

  typedef enum logic [1:0] {EM_ITEM, EM_RDATA, EM_PAD, EM_MARK} emit_sel_t;

  typedef enum logic [2:0] {
    IX_HOLD, IX_ZERO, IX_LAST, IX_PADSTART, IX_INC, IX_DEC
  } idx_op_t;

  typedef enum logic {KP_SCAN, KP_LEN} keep_sel_t;

  typedef struct packed {
    logic      latch;      // capture input beat
    logic      step;       // advance block phase, mark data seen
    logic      pop;        // drop oldest held byte
    logic      push;       // append item byte to window
    logic      emit;       // load output register
    emit_sel_t emit_sel;
    logic      emit_last;
    idx_op_t   idx_op;
    logic      keep_load;
    keep_sel_t keep_sel;
    logic      len_load;
    logic      st_load;
    status_t   st_code;
    logic      clear;      // end of message
  } cmd_t;

  typedef struct packed {
    logic    unpad;
    scheme_t scheme;
    logic    item_nob;
    logic    item_eom;
    logic    slot;         // output register free this cycle
    logic    win_full;
    logic    aligned;
    logic    seen;
    logic    fill_zero;
    logic    pad_tail;
    logic    idx_zero;
    logic    rd_zero;
    logic    len_bad;
    logic    len_one;
    logic    byte_bad;
    logic    chk_done;
    logic    rel_last;
    logic    keep_zero;
  } stat_t;

endpackage

// File: design/bpc_ctrl.sv
// Sequencing state machine for the block padding codec.
// Drives bpc_datapath through cmd_t, reacts to stat_t. Uses bpc_pkg.
module bpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  bpc_pkg::stat_t  stat,
  output bpc_pkg::cmd_t   cmd
);
  import bpc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_ITEM;
        end
      end
      S_ITEM: begin
        if (stat.item_nob) begin
          state_nxt = stat.item_eom ? S_END : S_IDLE;
        end else begin
          cmd.step = 1'b1;
          if (!stat.unpad) begin
            state_nxt = S_BYTE;
          end else if (stat.win_full) begin
            cmd.idx_op = IX_ZERO;
            state_nxt  = S_POP_WAIT;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_BYTE: begin
        if (stat.slot) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EM_ITEM;
          cmd.emit_last = stat.item_eom && stat.fill_zero;
          if (!stat.item_eom) begin
            state_nxt = S_IDLE;
          end else if (stat.fill_zero) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_op = IX_ZERO;
            state_nxt  = S_PAD;
          end
        end
      end
      S_POP_WAIT: state_nxt = S_POP;
      S_POP: begin
        if (stat.slot) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_RDATA;
          cmd.pop      = 1'b1;
          state_nxt    = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = stat.item_eom ? S_END : S_IDLE;
      end
      S_END: begin
        cmd.st_load = 1'b1;
        cmd.st_code = ST_OK;
        if (!stat.unpad) begin
          if (stat.fill_zero) begin
            state_nxt = S_MARK;
          end else begin
            cmd.idx_op = IX_ZERO;
            state_nxt  = S_PAD;
          end
        end else if (!stat.seen) begin
          cmd.st_code = ST_EMPTY;
          state_nxt   = S_MARK;
        end else if (!stat.aligned) begin
          cmd.st_code = ST_ALIGN;
          state_nxt   = S_MARK;
        end else begin
          cmd.idx_op = IX_LAST;
          state_nxt  = (stat.scheme == SCH_ZERO) ? S_ZWAIT : S_LWAIT;
        end
      end
      S_PAD: begin
        if (stat.slot) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EM_PAD;
          cmd.emit_last = stat.pad_tail;
          cmd.idx_op    = IX_INC;
          if (stat.pad_tail) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_ZWAIT: state_nxt = S_ZCHK;
      S_ZCHK: begin
        if (stat.rd_zero) begin
          if (stat.idx_zero) begin
            state_nxt = S_MARK;
          end else begin
            cmd.idx_op = IX_DEC;
            state_nxt  = S_ZWAIT;
          end
        end else begin
          cmd.keep_load = 1'b1;
          cmd.keep_sel  = KP_SCAN;
          cmd.idx_op    = IX_ZERO;
          state_nxt     = S_RWAIT;
        end
      end
      S_LWAIT: state_nxt = S_LCHK;
      S_LCHK: begin
        if (stat.len_bad) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_PADLEN;
          state_nxt   = S_MARK;
        end else begin
          cmd.keep_load = 1'b1;
          cmd.keep_sel  = KP_LEN;
          cmd.len_load  = 1'b1;
          if (stat.scheme == SCH_ISO || stat.len_one) begin
            state_nxt = S_RSTART;
          end else begin
            cmd.idx_op = IX_PADSTART;
            state_nxt  = S_CWAIT;
          end
        end
      end
      S_CWAIT: state_nxt = S_CCHK;
      S_CCHK: begin
        if (stat.byte_bad) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_PADBYT;
          state_nxt   = S_MARK;
        end else if (stat.chk_done) begin
          state_nxt = S_RSTART;
        end else begin
          cmd.idx_op = IX_INC;
          state_nxt  = S_CWAIT;
        end
      end
      S_RSTART: begin
        if (stat.keep_zero) begin
          state_nxt = S_MARK;
        end else begin
          cmd.idx_op = IX_ZERO;
          state_nxt  = S_RWAIT;
        end
      end
      S_RWAIT: state_nxt = S_REL;
      S_REL: begin
        if (stat.slot) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EM_RDATA;
          cmd.emit_last = stat.rel_last;
          if (stat.rel_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_op = IX_INC;
            state_nxt  = S_RWAIT;
          end
        end
      end
      S_MARK: begin
        if (stat.slot) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EM_MARK;
          cmd.emit_last = 1'b1;
          cmd.clear     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: design/bpc_datapath.sv
// Datapath of the block padding codec: config registers, item latch, circular
// hold window (memory), scan index, pad generation and output register. Uses bpc_pkg.
module bpc_datapath #(
  parameter int MAX_BLOCK = bpc_pkg::MAX_BLOCK_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::BSIZE_W-1:0]       cfg_data,
  input  logic [15:0]                       in_tdata,
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,
  output logic                              out_tlast,
  output logic [3:0]                        out_tuser,
  input  bpc_pkg::cmd_t                     cmd,
  output bpc_pkg::stat_t                    stat
);
  import bpc_pkg::*;

  localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int CW = $clog2(MAX_BLOCK + 1);
  localparam logic [AW:0]         DEPTH = (AW+1)'(MAX_BLOCK);
  localparam logic [CW-1:0]       MAXV  = CW'(MAX_BLOCK);
  localparam logic [BSIZE_W-1:0]  MAXB  = BSIZE_W'(MAX_BLOCK);

  // config
  scheme_t            scheme_r;
  logic               unpad_r;
  logic [BSIZE_W-1:0] bsize_r;
  logic               cfg_hit;
  logic [CW-1:0]      bs;

  // item latch
  logic [7:0] item_byte_r, item_rnd_r;
  logic       item_nob_r, item_eom_r;

  // message state
  logic [CW-1:0] phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic          seen_r;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] keep_r;
  logic [7:0]    len_r;
  status_t       status_r;

  // window memory
  logic [7:0]    mem [MAX_BLOCK];
  logic [7:0]    rdata_r;
  logic [AW-1:0] raddr, waddr;

  // output register
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_has_r, out_last_r;
  status_t       out_st_r;

  logic [CW:0]   ph_inc;
  logic [CW-1:0] fill;
  logic          pad_tail;
  logic [7:0]    pad_val;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH) s = s - DEPTH;
    return s[AW-1:0];
  endfunction

  assign cfg_hit = cfg_we && (cfg_index == REG_SCHEME || cfg_index == REG_MODE ||
                              cfg_index == REG_BSIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r <= SCH_PKCS7;
      unpad_r  <= 1'b0;
      bsize_r  <= BSIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCHEME: scheme_r <= scheme_t'(cfg_data[1:0]);
        REG_MODE:   unpad_r  <= cfg_data[0];
        REG_BSIZE:  bsize_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective block size: 0 acts as 1, clipped to window depth
  always_comb begin
    if (bsize_r == '0) begin
      bs = CW'(1);
    end else if (bsize_r > MAXB) begin
      bs = MAXV;
    end else begin
      bs = bsize_r[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_byte_r <= in_tdata[7:0];
      item_rnd_r  <= in_tdata[15:8];
      item_nob_r  <= in_tuser;
      item_eom_r  <= in_tlast;
    end
  end

  assign ph_inc = {1'b0, phase_r} + (CW+1)'(1);
  assign raddr  = wrap_add(head_r, idx_r);
  assign waddr  = wrap_add(head_r, cnt_r[AW-1:0]);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    if (cfg_hit || cmd.clear) begin
      phase_nxt = '0;
      cnt_nxt   = '0;
      head_nxt  = '0;
    end else begin
      if (cmd.step) phase_nxt = (ph_inc >= {1'b0, bs}) ? '0 : ph_inc[CW-1:0];
      if (cmd.pop) begin
        cnt_nxt  = cnt_r - CW'(1);
        head_nxt = wrap_add(head_r, AW'(1));
      end
      if (cmd.push) cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      cnt_r   <= '0;
      head_r  <= '0;
      seen_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      if (cfg_hit || cmd.clear) begin
        seen_r <= 1'b0;
      end else if (cmd.step) begin
        seen_r <= 1'b1;
      end
    end
  end

  always_comb begin
    unique case (cmd.idx_op)
      IX_HOLD:     idx_nxt = idx_r;
      IX_ZERO:     idx_nxt = '0;
      IX_LAST:     idx_nxt = AW'(bs - CW'(1));
      IX_PADSTART: idx_nxt = AW'(8'(bs) - rdata_r);
      IX_INC:      idx_nxt = idx_r + AW'(1);
      IX_DEC:      idx_nxt = idx_r - AW'(1);
      default:     idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.keep_load) begin
      keep_r <= (cmd.keep_sel == KP_SCAN) ? CW'(idx_r) + CW'(1) : bs - CW'(rdata_r);
    end
    if (cmd.len_load) len_r <= rdata_r;
    if (cmd.st_load) status_r <= cmd.st_code;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) mem[waddr] <= item_byte_r;
    rdata_r <= mem[raddr];
  end

  // pad generation
  assign fill     = bs - phase_r;
  assign pad_tail = (CW'(idx_r) + CW'(1)) == fill;

  always_comb begin
    if (scheme_r == SCH_ZERO) begin
      pad_val = 8'h00;
    end else if (scheme_r == SCH_PKCS7 || pad_tail) begin
      pad_val = 8'(fill);
    end else if (scheme_r == SCH_X923) begin
      pad_val = 8'h00;
    end else begin
      pad_val = item_rnd_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last_r <= cmd.emit_last;
      out_has_r  <= 1'b1;
      out_st_r   <= ST_OK;
      case (cmd.emit_sel)
        EM_ITEM:  out_byte_r <= item_byte_r;
        EM_RDATA: out_byte_r <= rdata_r;
        EM_PAD:   out_byte_r <= pad_val;
        default: begin
          out_byte_r <= 8'h00;
          out_has_r  <= 1'b0;
          out_st_r   <= status_r;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_st_r, out_has_r};

  // status to controller
  always_comb begin
    stat.unpad     = unpad_r;
    stat.scheme    = scheme_r;
    stat.item_nob  = item_nob_r;
    stat.item_eom  = item_eom_r;
    stat.slot      = !out_valid_r || out_tready;
    stat.win_full  = cnt_r == bs;
    stat.aligned   = (phase_r == '0) && (cnt_r == bs);
    stat.seen      = seen_r;
    stat.fill_zero = (scheme_r == SCH_ZERO) && (phase_r == '0);
    stat.pad_tail  = pad_tail;
    stat.idx_zero  = idx_r == '0;
    stat.rd_zero   = rdata_r == 8'h00;
    stat.len_bad   = (rdata_r == 8'h00) || (rdata_r > 8'(bs));
    stat.len_one   = rdata_r == 8'd1;
    stat.byte_bad  = (scheme_r == SCH_X923) ? (rdata_r != 8'h00) : (rdata_r != len_r);
    stat.chk_done  = ((CW+1)'(idx_r) + (CW+1)'(2)) == {1'b0, bs};
    stat.rel_last  = (CW'(idx_r) + CW'(1)) == keep_r;
    stat.keep_zero = keep_r == '0;
  end

endmodule

// File: design/block_padding_codec_unit.sv
// Top level of the block padding codec (zeros, ANSI X.923, PKCS7, ISO10126).
// Instantiates bpc_ctrl and bpc_datapath; uses bpc_pkg.
//
// Usage
//   in_*  : message beats. tlast ends a message; tuser set means a beat without a
//           byte (ends the message, or is ignored when tlast is low).
//   out_* : result beats. tlast marks the final result; tuser[0] low is a bare end
//           marker; tuser[3:1] carries the unpad status, non-zero only on tlast.
//   cfg_* : register writes (0 scheme, 1 unpad mode, 2 block size), only when idle.
//           A write to a listed register also abandons any message in progress.
// Timing
//   One beat is worked on at a time. Pad mode: a byte beat passes the item and byte
//   states. Unpad mode: a byte goes to the hold window until it is full; after that
//   the oldest byte is first read from memory and released. At message end, padding
//   emits the fill bytes in turn; unpadding scans the final block and releases it
//   through a wait and a release state per byte, for the registered memory read.
// Reset and stall
//   Reset restores PKCS7, pad mode, block size 16 and an empty message; the window
//   memory needs no clearing. A result waits in the output register while the next
//   input beat is taken; the sequencer only stalls when it must emit another beat.
module block_padding_codec_unit #(
  parameter int MAX_BLOCK = bpc_pkg::MAX_BLOCK_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config
  input  logic                          cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::BSIZE_W-1:0]   cfg_data,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [7:0] data_byte, [15:8] random_fill
  input  logic                          in_tlast,   // end_of_message
  input  logic                          in_tuser,   // [0] no_byte
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_byte
  output logic                          out_tlast,  // out_last
  output logic [3:0]                    out_tuser   // [0] has_byte, [3:1] status
);
  import bpc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpc_datapath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

  // a new result must never overwrite one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");

  // the sequencer is not ready in the cycle after it takes a beat
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while beat in progress");

  // error status only on a bare final marker
  a_status_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[3:1] != ST_OK)) |-> (out_tlast && !out_tuser[0]))
    else $error("status on a data beat");

endmodule

// File: dv/block_padding_codec_unit_tb.sv
// Self-checking testbench for block_padding_codec_unit, pad and unpad directions.
// Drives message beats, predicts every result beat in-bench and checks them in order.
// Depends on bpc_pkg and the block_padding_codec_unit RTL.
module block_padding_codec_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int MAXB       = MAX_BLOCK_DEF;
  localparam int SETTLE_CYC = 64;          // covers the slowest beat still being worked on
  localparam int DRAIN_CYC  = 20_000;      // bound on the final wait for results
  localparam int LIMIT_CYC  = 1_500_000;   // watchdog, far above the slowest correct run
  localparam int CLK_HALF   = 6;

  // index 3 maps to no register; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // one result beat as the block presents it
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
    status_t    st;
  } out_beat_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT signals
  // ---------------------------------------------------------------------------
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BSIZE_W-1:0]   cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;   // [7:0] data_byte, [15:8] random_fill
  logic                 in_tlast   = 1'b0; // end_of_message
  logic                 in_tuser   = 1'b0; // [0] no_byte
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;         // [7:0] out_byte
  logic                 out_tlast;         // out_last
  logic [3:0]           out_tuser;         // [0] has_byte, [3:1] status

  always #CLK_HALF clk = ~clk;

  block_padding_codec_unit #(.MAX_BLOCK(MAXB)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // ---------------------------------------------------------------------------
  // Run bookkeeping
  // ---------------------------------------------------------------------------
  int sender_idle_pct = 0;   // chance per cycle that the sender holds back a beat
  int sink_stall_pct  = 0;   // chance per cycle that out_tready is low
  int failures        = 0;
  int beats_sent      = 0;   // beats that carry a byte or end a message
  int beats_checked   = 0;
  int messages        = 0;

  // ---------------------------------------------------------------------------
  // Codec predictor: own copy of registers and message state
  // ---------------------------------------------------------------------------
  scheme_t            m_scheme  = SCH_PKCS7;
  logic               m_unpad   = 1'b0;
  logic [BSIZE_W-1:0] m_bsize   = BSIZE_RESET;
  logic [7:0]         m_win [MAXB];          // unpad hold-back window, oldest first
  int                 m_win_cnt = 0;
  int                 m_phase   = 0;         // message length mod block length
  bit                 m_seen    = 1'b0;

  out_beat_t due_beats [$];                  // predicted beats not yet seen at the output
  out_beat_t step_buf [MAXB + 2];
  int        step_n;

  logic [7:0] msg_bytes [$];                 // message being built for the random part

  // zero acts as one, oversize values clamp to the window depth
  function automatic int block_len();
    if (m_bsize == 0) return 1;
    if (m_bsize > MAXB) return MAXB;
    return int'(m_bsize);
  endfunction

  function automatic void add_out(logic [7:0] b, logic has, status_t st);
    step_buf[step_n] = '{data: b, has: has, last: 1'b0, st: st};
    step_n++;
  endfunction

  function automatic void drop_message();
    m_win_cnt = 0;
    m_phase   = 0;
    m_seen    = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [BSIZE_W-1:0] val);
    case (idx)
      REG_SCHEME: m_scheme = scheme_t'(val[1:0]);
      REG_MODE:   m_unpad  = val[0];
      REG_BSIZE:  m_bsize  = val;
      default:    return;
    endcase
    drop_message();
  endfunction

  // Works out the result beats one accepted input beat causes and queues them.
  function automatic void predict_codec_beat(logic [7:0] b, logic nob, logic eom,
                                             logic [7:0] rnd);
    int         bs;
    int         fill;
    int         keep;
    int         plen;
    status_t    st;
    logic [7:0] v;
    bs     = block_len();
    step_n = 0;
    if (m_phase >= bs) m_phase = 0;
    if (m_win_cnt > bs) m_win_cnt = 0;

    if (!nob) begin
      m_seen  = 1'b1;
      m_phase = (m_phase + 1 >= bs) ? 0 : m_phase + 1;
      if (!m_unpad) begin
        add_out(b, 1'b1, ST_OK);
      end else begin
        // window full: the oldest byte can no longer be pad, release it
        if (m_win_cnt >= bs) begin
          add_out(m_win[0], 1'b1, ST_OK);
          for (int i = 0; i < m_win_cnt - 1; i++) m_win[i] = m_win[i + 1];
          m_win_cnt--;
        end
        m_win[m_win_cnt] = b;
        m_win_cnt++;
      end
    end

    if (eom) begin
      if (!m_unpad) begin
        fill = bs - m_phase;
        if (m_scheme == SCH_ZERO && m_phase == 0) fill = 0;
        for (int i = 0; i < fill; i++) begin
          if (m_scheme == SCH_ZERO) v = 8'h00;
          else if (m_scheme == SCH_PKCS7 || i == fill - 1) v = 8'(fill);
          else if (m_scheme == SCH_X923) v = 8'h00;
          else v = rnd;
          add_out(v, 1'b1, ST_OK);
        end
        if (step_n == 0) add_out(8'h00, 1'b0, ST_OK);
      end else begin
        st   = ST_OK;
        keep = 0;
        if (!m_seen) begin
          st = ST_EMPTY;
        end else if (m_phase != 0 || m_win_cnt != bs) begin
          st = ST_ALIGN;
        end else if (m_scheme == SCH_ZERO) begin
          // strip trailing zeros, final block only
          keep = bs;
          while (keep > 0 && m_win[keep - 1] == 8'h00) keep--;
        end else begin
          plen = m_win[bs - 1];
          if (plen == 0 || plen > bs) begin
            st = ST_PADLEN;
          end else begin
            for (int i = bs - plen; i < bs - 1; i++) begin
              if (m_scheme == SCH_X923 && m_win[i] != 8'h00) st = ST_PADBYT;
              if (m_scheme == SCH_PKCS7 && m_win[i] != 8'(plen)) st = ST_PADBYT;
            end
            keep = bs - plen;
          end
        end
        if (st == ST_OK)
          for (int i = 0; i < keep; i++) add_out(m_win[i], 1'b1, ST_OK);
        if (st != ST_OK || keep == 0) add_out(8'h00, 1'b0, st);
      end
      step_buf[step_n - 1].last = 1'b1;
      drop_message();
    end

    for (int i = 0; i < step_n; i++) due_beats.push_back(step_buf[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order compare
  // ---------------------------------------------------------------------------
  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("[%0t] ERROR %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : result_check
    out_beat_t want;
    out_beat_t got;
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= sink_stall_pct);

    if (rst_n && out_tvalid && out_tready) begin
      got = '{data: out_tdata, has: out_tuser[0], last: out_tlast,
              st: status_t'(out_tuser[3:1])};
      beats_checked++;
      if (due_beats.size() == 0) begin
        note_failure($sformatf("unexpected beat: byte %02h has %0b last %0b status %0d",
                               got.data, got.has, got.last, got.st));
      end else begin
        want = due_beats.pop_front();
        if (got.data !== want.data || got.has !== want.has ||
            got.last !== want.last || got.st !== want.st)
          note_failure($sformatf({"beat %0d: exp byte %02h has %0b last %0b status %0d, ",
                                  "got byte %02h has %0b last %0b status %0d"},
                                 beats_checked, want.data, want.has, want.last, want.st,
                                 got.data, got.has, got.last, got.st));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Returns at the edge the beat is taken, tvalid still high; the caller either
  // drives the next beat or drops tvalid at that same edge.
  task automatic send_beat(logic [7:0] b, logic nob, logic eom, logic [7:0] rnd);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rnd, b};
    in_tlast  <= eom;
    in_tuser  <= nob;
    do @(posedge clk); while (!in_tready);
    predict_codec_beat(b, nob, eom, rnd);
    if (!nob || eom) beats_sent++;
  endtask

  // Always waits on the clock before returning, so tvalid never sees two updates in one step.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_beats.size() != 0);
  endtask

  // Only with the block idle: results drained, then time for any silent beat.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BSIZE_W-1:0] val);
    wait_results();
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic set_config(scheme_t s, logic unpad, logic [BSIZE_W-1:0] bs);
    write_reg(REG_SCHEME, BSIZE_W'(s));
    write_reg(REG_MODE, BSIZE_W'(unpad));
    write_reg(REG_BSIZE, bs);
  endtask

  // Sends msg_bytes with the odd ignored beat mixed in; the message ends either on
  // its last byte or on a separate byte-less end beat. hold_mid pauses halfway
  // until every predicted result has arrived.
  task automatic send_message(bit sep_end, bit hold_mid);
    int n;
    n = msg_bytes.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) send_beat(8'($urandom), 1'b1, 1'b0, 8'($urandom));
      if (hold_mid && i == n / 2) wait_results();
      send_beat(msg_bytes[i], 1'b0, (i == n - 1) && !sep_end, 8'($urandom));
    end
    if (n == 0 || sep_end) send_beat(8'($urandom), 1'b1, 1'b1, 8'($urandom));
    messages++;
  endtask

  function automatic void build_plain(int len);
    msg_bytes.delete();
    for (int i = 0; i < len; i++) msg_bytes.push_back(8'($urandom));
  endfunction

  // Correctly padded message for the current scheme and block length.
  function automatic void build_padded();
    int bs;
    int plen;
    int total;
    bs    = block_len();
    total = (bs > 8) ? bs : bs * $urandom_range(1, 2);
    msg_bytes.delete();
    if (m_scheme == SCH_ZERO) begin
      plen = $urandom_range(0, bs);
      for (int i = 0; i < total - plen; i++) msg_bytes.push_back(8'($urandom));
      for (int i = 0; i < plen; i++) msg_bytes.push_back(8'h00);
    end else begin
      plen = $urandom_range(1, bs);
      for (int i = 0; i < total - plen; i++) msg_bytes.push_back(8'($urandom));
      for (int i = 1; i < plen; i++)
        case (m_scheme)
          SCH_X923:  msg_bytes.push_back(8'h00);
          SCH_PKCS7: msg_bytes.push_back(8'(plen));
          default:   msg_bytes.push_back(8'($urandom));
        endcase
      msg_bytes.push_back(8'(plen));
    end
  endfunction

  // Breaks a padded message: length off by one, bad length byte, bad fill, or empty.
  function automatic void spoil_padded();
    int n;
    n = msg_bytes.size();
    case ($urandom_range(4))
      0: if ($urandom_range(1) == 0) void'(msg_bytes.pop_back());
         else msg_bytes.push_back(8'($urandom));
      1: msg_bytes[n - 1] = 8'h00;
      2: msg_bytes[n - 1] = 8'($urandom_range(block_len() + 1, 255));
      3: if (n >= 2) msg_bytes[n - 2] = msg_bytes[n - 2] ^ 8'($urandom_range(1, 255));
      default: msg_bytes.delete();
    endcase
  endfunction

  // Mostly small blocks; the window depth, zero and oversize now and then.
  task automatic random_config();
    int r;
    logic [BSIZE_W-1:0] bs;
    r = $urandom_range(99);
    if (r < 80)      bs = BSIZE_W'($urandom_range(1, 8));
    else if (r < 88) bs = BSIZE_W'(MAXB);
    else if (r < 92) bs = '0;
    else if (r < 96) bs = BSIZE_W'($urandom_range(MAXB + 1, 63));
    else             bs = BSIZE_W'($urandom_range(9, MAXB - 1));
    // upper data bits are junk for the narrow registers
    write_reg(REG_SCHEME, BSIZE_W'($urandom_range(63)));
    write_reg(REG_MODE, BSIZE_W'($urandom_range(63)));
    write_reg(REG_BSIZE, bs);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Pad direction: reset settings, every scheme, aligned and empty messages,
  // ignored beats, and a register write abandoning a message.
  task automatic test_pad_directed();
    send_beat(8'hFF, 1'b0, 1'b1, 8'h00);          // PKCS7, block 16 out of reset
    send_beat(8'h00, 1'b1, 1'b0, 8'hFF);          // no byte, no end: ignored
    set_config(SCH_ZERO, 1'b0, 6'd2);
    send_beat(8'h00, 1'b0, 1'b1, 8'hFF);          // one zero appended
    send_beat(8'hFF, 1'b0, 1'b0, 8'h00);
    send_beat(8'h01, 1'b0, 1'b1, 8'h00);          // aligned: nothing appended
    send_beat(8'h00, 1'b1, 1'b1, 8'h00);          // empty: bare end marker
    set_config(SCH_X923, 1'b0, 6'd3);
    send_beat(8'hAA, 1'b0, 1'b1, 8'hFF);
    set_config(SCH_ISO, 1'b0, 6'd3);
    send_beat(8'h00, 1'b1, 1'b1, 8'hA5);          // empty: a full block of fill
    send_beat(8'h5A, 1'b0, 1'b1, 8'hFF);
    // a write mid-message restarts the block phase
    set_config(SCH_PKCS7, 1'b0, 6'd3);
    send_beat(8'h11, 1'b0, 1'b0, 8'h00);
    write_reg(REG_BSIZE, 6'd3);
    send_beat(8'h22, 1'b0, 1'b1, 8'h00);
  endtask

  // Unpad direction, block 2: good pads, each error status, zero stripping.
  task automatic test_unpad_directed();
    set_config(SCH_PKCS7, 1'b1, 6'd2);
    send_beat(8'h10, 1'b0, 1'b0, 8'h00);
    send_beat(8'h01, 1'b0, 1'b1, 8'h00);          // keeps one byte
    send_beat(8'h02, 1'b0, 1'b0, 8'h00);
    send_beat(8'h02, 1'b0, 1'b1, 8'h00);          // whole block is pad
    send_beat(8'hFF, 1'b1, 1'b1, 8'hFF);          // empty message
    send_beat(8'h01, 1'b0, 1'b1, 8'h00);          // not a block multiple
    send_beat(8'h05, 1'b0, 1'b0, 8'h00);
    send_beat(8'h00, 1'b0, 1'b1, 8'h00);          // zero length byte
    send_beat(8'h05, 1'b0, 1'b0, 8'h00);
    send_beat(8'h03, 1'b0, 1'b1, 8'h00);          // length above block
    send_beat(8'h01, 1'b0, 1'b0, 8'h00);
    send_beat(8'h02, 1'b0, 1'b1, 8'h00);          // fill byte is not the length
    // held byte dropped by a register write
    send_beat(8'h11, 1'b0, 1'b0, 8'h00);
    write_reg(REG_MODE, 6'd1);
    send_beat(8'h33, 1'b0, 1'b0, 8'h00);
    send_beat(8'h01, 1'b0, 1'b1, 8'h00);
    set_config(SCH_X923, 1'b1, 6'd2);
    send_beat(8'h09, 1'b0, 1'b0, 8'h00);
    send_beat(8'h02, 1'b0, 1'b1, 8'h00);          // ANSI fill must be zero
    set_config(SCH_ZERO, 1'b1, 6'd2);
    send_beat(8'h00, 1'b0, 1'b0, 8'h00);
    send_beat(8'h00, 1'b0, 1'b1, 8'h00);          // all stripped, still ok
    send_beat(8'h7E, 1'b0, 1'b0, 8'h00);
    send_beat(8'h00, 1'b0, 1'b1, 8'h00);
    set_config(SCH_ISO, 1'b1, 6'd2);
    send_beat(8'h77, 1'b0, 1'b0, 8'h00);
    send_beat(8'h02, 1'b0, 1'b1, 8'h00);          // ISO fill is not checked
  endtask

  // Block length zero and oversize, and a write to the unmapped index.
  task automatic test_block_size_limits();
    set_config(SCH_PKCS7, 1'b0, 6'd0);
    send_beat(8'h3C, 1'b0, 1'b1, 8'h00);
    write_reg(REG_BSIZE, 6'd63);
    send_beat(8'h00, 1'b0, 1'b1, 8'h00);
    write_reg(REG_SPARE, 6'h3F);
    send_beat(8'hC3, 1'b0, 1'b1, 8'hFF);
  endtask

  // Random messages over four idling phases. Unpad traffic is mostly well padded
  // so the release and strip paths get exercised, the rest is broken.
  task automatic test_random_traffic();
    int target;
    int msg_cnt;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 58; end
        default: begin sender_idle_pct = 6; sink_stall_pct = 6; end
      endcase
      target  = beats_sent + 18;
      msg_cnt = 0;
      while (beats_sent < target) begin
        if (msg_cnt % 3 == 0) random_config();
        if (m_unpad) begin
          build_padded();
          if ($urandom_range(99) < 25) spoil_padded();
        end else begin
          build_plain($urandom_range(0, (block_len() > 8) ? block_len() + 2
                                                          : 2 * block_len() + 1));
        end
        send_message($urandom_range(1), msg_cnt == 1);
        msg_cnt++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    int waited;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pad_directed();
    test_unpad_directed();
    test_block_size_limits();
    test_random_traffic();

    // let the last results out, then watch for strays
    in_tvalid       <= 1'b0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    waited          = 0;
    while (due_beats.size() != 0 && waited < DRAIN_CYC) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    while (due_beats.size() != 0) begin
      void'(due_beats.pop_front());
      note_failure("predicted beat never arrived");
    end

    $display("Run covered %0d input beats in %0d random messages plus directed cases,",
             beats_sent, messages);
    $display("all schemes both ways, %0d result beats checked, %0d failures.",
             beats_checked, failures);
    if (failures == 0) begin
      $display("** block_padding_codec_unit: PASSED **");
    end else begin
      $display("** block_padding_codec_unit: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_CYC * 2 * CLK_HALF);
    $display("Timed out with %0d beats still awaited.", due_beats.size());
    $display("** block_padding_codec_unit: FAILED **");
    $finish;
  end

endmodule
